[src/assert_macros.svh]
// Assertion macros used by the verification checker of the voice allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock, off while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Concurrent assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

[src/svalloc_pkg.sv]
package svalloc_pkg;

    typedef enum logic [1:0] {
        REQ_NOTE_ON  = 2'd0,
        REQ_NOTE_OFF = 2'd1,
        REQ_ALL_OFF  = 2'd2,
        REQ_STATUS   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_STAT_RD,
        ST_STAT_WR,
        ST_PICK,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic        on;
        logic        rel;
        logic        drone;
        logic [31:0] note;
        logic [15:0] level;
        logic [31:0] stamp;
    } voice_t;

endpackage

[src/synth_voice_allocator_core.sv]
// Voice allocator for a polyphonic synthesizer. Every voice entry (flags, note id, level and
// age stamp) lives in a single synchronous memory with a registered read. Each accepted word
// yields exactly one result word. A note on, a note off or an all off walks the memory one entry per
// cycle, then a note on writes the picked entry in ST_PICK before its result is emitted; a
// status update is a read-modify-write of one entry (ST_STAT_RD, then ST_STAT_WR), skipped
// when the index lies outside the table. Input acceptance reopens in ST_IDLE, once the result
// is produced. A result waits in an output register, so the next word may be accepted while
// it is still pending; a second result stalls the block until the first is taken. Entries
// read as zero until first written, tracked by one valid flip-flop per voice that reset
// clears, so there is no clearing pass after reset.
module synth_voice_allocator_core #(
    parameter int VOICES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic signed [31:0] note_id,
    input  logic               hold_flag,
    input  logic [3:0]         status_voice,
    input  logic               status_active,
    input  logic               status_releasing,
    input  logic [15:0]        status_level,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         chosen_voice,
    output logic               retrigger,
    output logic               stolen,
    output logic [15:0]        released_mask
);
    import svalloc_pkg::*;

    localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CNT_W = $clog2(VOICES + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(VOICES);

    state_t state_reg, state_next;

    // Accepted word.
    req_t              req_reg;
    logic [31:0]       id_reg;
    logic              hold_reg;
    logic [IDX_W-1:0]  sv_reg;
    logic              sa_reg;
    logic              sr_reg;
    logic [15:0]       sl_reg;

    // Scan address and the stage that receives the read data.
    logic [CNT_W-1:0]  idx_reg;
    logic              p_vld_reg;
    logic [IDX_W-1:0]  p_addr_reg;
    logic              p_ok_reg;

    // Voice memory and its valid bits.
    voice_t            mem [VOICES];
    voice_t            rd_data_reg;
    voice_t            cur;
    logic [VOICES-1:0] vld_reg;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_ra;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa;
    voice_t            mem_wd;

    // Candidate trackers for a note on.
    logic              match_found_reg, free_found_reg, rel_found_reg;
    logic              nd_found_reg, old_found_reg;
    logic [IDX_W-1:0]  match_idx_reg, free_idx_reg, rel_idx_reg, nd_idx_reg, old_idx_reg;
    logic [15:0]       rel_level_reg;
    logic [31:0]       rel_stamp_reg, nd_stamp_reg, old_stamp_reg;
    logic              upd_match, upd_free, upd_rel, upd_nd, upd_old;
    logic              on_data, off_data, off_hit;
    logic [IDX_W-1:0]  pick_idx;

    logic [31:0]       stamp_reg;

    // Result of the word in work and the output register.
    logic [IDX_W-1:0]  res_voice_reg;
    logic              res_retrig_reg;
    logic              res_stolen_reg;
    logic [15:0]       mask_reg;
    logic              out_valid_reg;
    logic [3:0]        out_voice_reg;
    logic              out_retrig_reg;
    logic              out_stolen_reg;
    logic [15:0]       out_mask_reg;

    logic              accept;
    logic              emit;
    logic              stat_in_range;

    assign accept        = in_valid && in_ready;
    assign emit          = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    assign stat_in_range = 32'(status_voice) < VOICES;

    assign cur = p_ok_reg ? rd_data_reg : '0;

    assign on_data  = (state_reg == ST_SCAN) && p_vld_reg && (req_reg == REQ_NOTE_ON);
    assign off_data = (state_reg == ST_SCAN) && p_vld_reg && (req_reg != REQ_NOTE_ON);
    assign off_hit  = off_data && cur.on && ((req_reg == REQ_ALL_OFF) || (cur.note == id_reg));

    assign upd_match = on_data && !match_found_reg && cur.on && (cur.note == id_reg);
    assign upd_free  = on_data && !free_found_reg && !cur.on;
    assign upd_rel   = on_data && cur.rel && !cur.drone &&
                       (!rel_found_reg || (cur.level < rel_level_reg) ||
                        ((cur.level == rel_level_reg) && (cur.stamp < rel_stamp_reg)));
    assign upd_nd    = on_data && !cur.drone && (!nd_found_reg || (cur.stamp < nd_stamp_reg));
    assign upd_old   = on_data && (!old_found_reg || (cur.stamp < old_stamp_reg));

    always_comb
    begin
        if (match_found_reg)
            pick_idx = match_idx_reg;
        else if (free_found_reg)
            pick_idx = free_idx_reg;
        else if (rel_found_reg)
            pick_idx = rel_idx_reg;
        else if (nd_found_reg)
            pick_idx = nd_idx_reg;
        else
            pick_idx = old_idx_reg;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_t'(req_type) == REQ_STATUS)
                        state_next = stat_in_range ? ST_STAT_RD : ST_EMIT;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == LAST_CNT)
                    state_next = (req_reg == REQ_NOTE_ON) ? ST_PICK : ST_EMIT;
            end
            ST_STAT_RD: state_next = ST_STAT_WR;
            ST_STAT_WR: state_next = ST_EMIT;
            ST_PICK:    state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Handshake and memory port controls.
    always_comb
    begin
        in_ready = 1'b0;
        mem_re   = 1'b0;
        mem_ra   = idx_reg[IDX_W-1:0];
        mem_we   = 1'b0;
        mem_wa   = p_addr_reg;
        mem_wd   = cur;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_SCAN:
            begin
                mem_re = (idx_reg != LAST_CNT);
                // The write-back goes to the entry whose data is in the read register, never to the one being read.
                if (off_hit)
                begin
                    mem_we     = 1'b1;
                    mem_wd.rel = 1'b1;
                end
            end
            ST_STAT_RD:
            begin
                mem_re = 1'b1;
                mem_ra = sv_reg;
            end
            ST_STAT_WR:
            begin
                mem_we       = 1'b1;
                mem_wa       = sv_reg;
                mem_wd.on    = sa_reg;
                mem_wd.rel   = sr_reg;
                mem_wd.level = sl_reg;
            end
            ST_PICK:
            begin
                mem_we       = 1'b1;
                mem_wa       = pick_idx;
                mem_wd.on    = 1'b1;
                mem_wd.rel   = 1'b0;
                mem_wd.drone = hold_reg;
                mem_wd.note  = id_reg;
                mem_wd.level = '0;
                mem_wd.stamp = stamp_reg + 32'd1;
            end
            ST_EMIT:
            begin
                mem_re = 1'b0;
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (mem_re)
            rd_data_reg <= mem[mem_ra];
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            p_vld_reg       <= 1'b0;
            vld_reg         <= '0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            rel_found_reg   <= 1'b0;
            nd_found_reg    <= 1'b0;
            old_found_reg   <= 1'b0;
            stamp_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            p_vld_reg <= (state_reg == ST_SCAN) && mem_re;
            if (mem_we)
                vld_reg[mem_wa] <= 1'b1;
            if (accept)
            begin
                idx_reg         <= '0;
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
                rel_found_reg   <= 1'b0;
                nd_found_reg    <= 1'b0;
                old_found_reg   <= 1'b0;
            end
            else
            begin
                if ((state_reg == ST_SCAN) && mem_re)
                    idx_reg <= idx_reg + CNT_W'(1);
                if (upd_match)
                    match_found_reg <= 1'b1;
                if (upd_free)
                    free_found_reg <= 1'b1;
                if (upd_rel)
                    rel_found_reg <= 1'b1;
                if (upd_nd)
                    nd_found_reg <= 1'b1;
                if (upd_old)
                    old_found_reg <= 1'b1;
            end
            if (state_reg == ST_PICK)
                stamp_reg <= stamp_reg + 32'd1;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Data path.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg        <= req_t'(req_type);
            id_reg         <= note_id;
            hold_reg       <= hold_flag;
            sv_reg         <= IDX_W'(status_voice);
            sa_reg         <= status_active;
            sr_reg         <= status_releasing;
            sl_reg         <= status_level;
            res_voice_reg  <= '0;
            res_retrig_reg <= 1'b0;
            res_stolen_reg <= 1'b0;
            mask_reg       <= '0;
        end
        if (mem_re)
        begin
            p_addr_reg <= mem_ra;
            p_ok_reg   <= vld_reg[mem_ra];
        end
        if (upd_match)
            match_idx_reg <= p_addr_reg;
        if (upd_free)
            free_idx_reg <= p_addr_reg;
        if (upd_rel)
        begin
            rel_idx_reg   <= p_addr_reg;
            rel_level_reg <= cur.level;
            rel_stamp_reg <= cur.stamp;
        end
        if (upd_nd)
        begin
            nd_idx_reg   <= p_addr_reg;
            nd_stamp_reg <= cur.stamp;
        end
        if (upd_old)
        begin
            old_idx_reg   <= p_addr_reg;
            old_stamp_reg <= cur.stamp;
        end
        // Voices beyond the sixteenth shift out of the mask.
        if (off_hit)
            mask_reg <= mask_reg | (16'd1 << p_addr_reg);
        if (state_reg == ST_PICK)
        begin
            res_voice_reg  <= pick_idx;
            res_retrig_reg <= match_found_reg;
            res_stolen_reg <= !match_found_reg && !free_found_reg;
        end
        if (emit)
        begin
            out_voice_reg  <= 4'(res_voice_reg);
            out_retrig_reg <= res_retrig_reg;
            out_stolen_reg <= res_stolen_reg;
            out_mask_reg   <= mask_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign chosen_voice  = out_voice_reg;
    assign retrigger     = out_retrig_reg;
    assign stolen        = out_stolen_reg;
    assign released_mask = out_mask_reg;

endmodule

[src/svalloc_checker.sv]
`include "assert_macros.svh"

module svalloc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  chosen_voice,
    input logic        retrigger,
    input logic        stolen,
    input logic [15:0] released_mask
);

    // A result word waits until it is taken, with its voice and mask held.
    `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)
    `ASSERT_CLK(a_out_stable, clk, rst_n,
                out_valid && !out_ready |=> $stable(chosen_voice) && $stable(released_mask))

    // One word is worked on at a time, so in_ready drops once a word is accepted.
    `ASSERT_CLK(a_one_at_a_time, clk, rst_n, in_valid && in_ready |=> !in_ready)

    // Retrigger and stolen are never both set; either one means an empty mask.
    `ASSERT_CLK(a_kind_excl, clk, rst_n, out_valid |-> !(retrigger && stolen))
    `ASSERT_CLK(a_note_on_mask, clk, rst_n,
                out_valid && (retrigger || stolen) |-> released_mask == 16'd0)

endmodule

bind synth_voice_allocator_core svalloc_checker u_svalloc_checker (.*);
